[rtl/core/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[rtl/core/skt_pkg.sv]
package skt_pkg;

  // default number of table entries
  localparam int POINTS_DEFAULT = 64;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SET  = 2'd1,
    OP_DEL  = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_INSERTED  = 4'd0,
    ST_REPLACED  = 4'd1,
    ST_SET       = 4'd2,
    ST_DELETED   = 4'd3,
    ST_READ      = 4'd4,
    ST_REFUSED   = 4'd5,
    ST_LAST_KEPT = 4'd6,
    ST_FULL      = 4'd7,
    ST_BAD_INDEX = 4'd8
  } status_e;

  // input transaction
  typedef struct packed {
    op_e                op;
    logic        [5:0]  index;
    logic signed [31:0] key_x;
    logic signed [31:0] value_y;
  } in_t;

  // result transaction
  typedef struct packed {
    status_e            status;
    logic        [5:0]  position;
    logic        [6:0]  entry_count;
    logic signed [31:0] read_x;
    logic signed [31:0] read_y;
  } out_t;

  // what one cell holds
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } entry_t;

  // action broadcast to every cell
  typedef enum logic [2:0] {
    CA_NONE,
    CA_CMP,
    CA_INSERT,
    CA_WRITE_Y,
    CA_WRITE_XY,
    CA_DELETE
  } cell_act_e;

  typedef struct packed {
    cell_act_e          act;
    logic        [5:0]  idx;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } cell_cmd_t;

  // per-cell compare results seen by the controller
  typedef struct packed {
    logic lt;
    logic refuse;
    logic boundary;
    logic first_eq;
  } cell_flags_t;

endpackage

[rtl/core/sorted_keyframe_table.sv]
// Sorted table of up to POINTS (x, y) keyframes in ascending signed x order,
// one entry per cell of a chain. Every transaction yields exactly one result.
// A transaction passes from acceptance through a compare state, in which all
// cells compare their x with the key and with their neighbors, an update
// state, in which the cells shift or write in parallel, and an output state
// that selects the entry at the result position, loads the result register
// once it is free and returns to idle for the next acceptance. Entry 0 holds
// (0, 0) after reset, count 1.
module sorted_keyframe_table #(
  parameter int POINTS = skt_pkg::POINTS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  skt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skt_pkg::out_t out_data_o
);

  localparam int CW  = $clog2(POINTS + 1);
  localparam int IW  = $clog2(POINTS);
  localparam int PW  = (IW > 6) ? IW : 6;
  localparam int XW  = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_OUT
  } state_e;

  state_e state_q;

  skt_pkg::in_t       req_q;
  logic [CW-1:0]      count_q, count_d;
  logic [PW-1:0]      pos_q, pos_d;
  skt_pkg::status_e   status_q, status_d;
  logic               show_q, show_d;
  logic               out_valid_q;
  skt_pkg::out_t      out_q;
  logic               out_load;

  skt_pkg::cell_cmd_t   cmd;
  skt_pkg::entry_t      ent   [POINTS];
  skt_pkg::cell_flags_t flags [POINTS];

  logic          found, refused, idx_ok, full;
  logic [PW-1:0] pos_add;
  logic signed [31:0] rd_x, rd_y;
  logic [XW-1:0] count_ext;

  // chain of cells
  for (genvar i = 0; i < POINTS; i++) begin : g_cell
    skt_pkg::entry_t prev_ent, next_ent;
    logic            prev_lt;
    if (i == 0) begin : g_first
      assign prev_ent = '0;
      assign prev_lt  = 1'b0;
    end else begin : g_mid
      assign prev_ent = ent[i-1];
      assign prev_lt  = flags[i-1].lt;
    end
    if (i == POINTS - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_up
      assign next_ent = ent[i+1];
    end
    skt_cell #(.IDX(i)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .prev_i    (prev_ent),
      .prev_lt_i (prev_lt),
      .next_i    (next_ent),
      .entry_o   (ent[i]),
      .flags_o   (flags[i])
    );
  end

  // combine the cell flags
  always_comb begin
    found   = 1'b0;
    refused = 1'b0;
    pos_add = '0;
    for (int i = 0; i < POINTS; i++) begin
      found   = found | flags[i].first_eq;
      refused = refused | flags[i].refuse;
      pos_add = pos_add | (flags[i].boundary ? PW'(i) : '0);
    end
  end

  assign idx_ok = ({26'd0, req_q.index} < 32'(count_q));
  assign full   = (count_q == CW'(POINTS));

  // issue the compare, then decide the operation during the update cycle
  always_comb begin
    cmd.act   = skt_pkg::CA_NONE;
    cmd.idx   = req_q.index;
    cmd.key   = req_q.key_x;
    cmd.value = req_q.value_y;
    count_d   = count_q;
    pos_d     = PW'(req_q.index);
    status_d  = skt_pkg::ST_BAD_INDEX;
    show_d    = 1'b0;
    if (state_q == S_CMP) begin
      cmd.act = skt_pkg::CA_CMP;
    end else if (state_q == S_UPD) begin
      if (req_q.op == skt_pkg::OP_ADD) begin
        if (found) begin
          cmd.act  = skt_pkg::CA_WRITE_Y;
          status_d = skt_pkg::ST_REPLACED;
          pos_d    = pos_add;
          show_d   = 1'b1;
        end else if (full) begin
          status_d = skt_pkg::ST_FULL;
          pos_d    = '0;
        end else begin
          cmd.act  = skt_pkg::CA_INSERT;
          status_d = skt_pkg::ST_INSERTED;
          pos_d    = pos_add;
          count_d  = count_q + CW'(1);
          show_d   = 1'b1;
        end
      end else if (idx_ok) begin
        show_d = 1'b1;
        case (req_q.op)
          skt_pkg::OP_SET: begin
            if (refused) begin
              status_d = skt_pkg::ST_REFUSED;
            end else begin
              cmd.act  = skt_pkg::CA_WRITE_XY;
              status_d = skt_pkg::ST_SET;
            end
          end
          skt_pkg::OP_DEL: begin
            if (count_q == CW'(1)) begin
              status_d = skt_pkg::ST_LAST_KEPT;
            end else begin
              cmd.act  = skt_pkg::CA_DELETE;
              status_d = skt_pkg::ST_DELETED;
              count_d  = count_q - CW'(1);
            end
          end
          default: status_d = skt_pkg::ST_READ;
        endcase
      end
    end
  end

  // select the entry at the result position from the updated cells
  always_comb begin
    rd_x = '0;
    rd_y = '0;
    for (int i = 0; i < POINTS; i++) begin
      if (show_q && ent[i].valid && (pos_q == PW'(i))) begin
        rd_x = rd_x | ent[i].key;
        rd_y = rd_y | ent[i].value;
      end
    end
  end

  assign count_ext = XW'(count_q);

  // result register takes a new transaction when it is empty or being drained
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CW'(1);
      out_valid_q <= 1'b0;
      show_q      <= 1'b0;
      pos_q       <= '0;
      status_q    <= skt_pkg::ST_READ;
      req_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            state_q <= S_CMP;
          end
        end
        S_CMP: state_q <= S_UPD;
        S_UPD: begin
          count_q  <= count_d;
          pos_q    <= pos_d;
          status_q <= status_d;
          show_q   <= show_d;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_q.status      <= status_q;
            out_q.position    <= pos_q[5:0];
            out_q.entry_count <= count_ext[6:0];
            out_q.read_x      <= rd_x;
            out_q.read_y      <= rd_y;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/skt_cell.sv]
module skt_cell #(
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skt_pkg::cell_cmd_t  cmd_i,
  input  skt_pkg::entry_t     prev_i,
  input  logic                prev_lt_i,
  input  skt_pkg::entry_t     next_i,
  output skt_pkg::entry_t     entry_o,
  output skt_pkg::cell_flags_t flags_o
);

  skt_pkg::entry_t ent_q, ent_d;
  logic lt_q, eq_q, refuse_q;
  logic is_sel, at_or_above, boundary;
  logic lt_now, eq_now, refuse_now;

  assign is_sel      = (IDX == int'(cmd_i.idx));
  assign at_or_above = (IDX >= int'(cmd_i.idx));

  // local compare against the broadcast key and the neighbor keys
  assign lt_now     = ent_q.valid && (ent_q.key < cmd_i.key);
  assign eq_now     = ent_q.valid && (ent_q.key == cmd_i.key);
  assign refuse_now = is_sel && (((IDX > 0) && (cmd_i.key < prev_i.key)) ||
                                 (next_i.valid && (cmd_i.key > next_i.key)));

  // first cell not below the key
  assign boundary = !lt_q && ((IDX == 0) || prev_lt_i);

  assign flags_o.lt       = lt_q;
  assign flags_o.refuse   = refuse_q;
  assign flags_o.boundary = boundary;
  assign flags_o.first_eq = eq_q && boundary;
  assign entry_o          = ent_q;

  // next content of the cell
  always_comb begin
    ent_d = ent_q;
    case (cmd_i.act)
      skt_pkg::CA_INSERT: begin
        if (!lt_q) begin
          if (boundary) begin
            ent_d.valid = 1'b1;
            ent_d.key   = cmd_i.key;
            ent_d.value = cmd_i.value;
          end else begin
            ent_d = prev_i;
          end
        end
      end
      skt_pkg::CA_WRITE_Y: begin
        if (eq_q && boundary) ent_d.value = cmd_i.value;
      end
      skt_pkg::CA_WRITE_XY: begin
        if (is_sel) begin
          ent_d.key   = cmd_i.key;
          ent_d.value = cmd_i.value;
        end
      end
      skt_pkg::CA_DELETE: begin
        if (at_or_above) ent_d = next_i;
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.valid <= (IDX == 0);
      ent_q.key   <= '0;
      ent_q.value <= '0;
      lt_q        <= 1'b0;
      eq_q        <= 1'b0;
      refuse_q    <= 1'b0;
    end else begin
      ent_q <= ent_d;
      if (cmd_i.act == skt_pkg::CA_CMP) begin
        lt_q     <= lt_now;
        eq_q     <= eq_now;
        refuse_q <= refuse_now;
      end
    end
  end

endmodule

[rtl/core/skt_checker.sv]
`include "assert_macros.svh"

module skt_checker #(
  parameter int POINTS = skt_pkg::POINTS_DEFAULT
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input skt_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input skt_pkg::out_t out_data_o
);

  logic in_fire;
  logic no_data;

  assign in_fire = in_valid_i && in_ready_o;
  assign no_data = (out_data_o.status == skt_pkg::ST_FULL) ||
                   (out_data_o.status == skt_pkg::ST_BAD_INDEX);

  // a stalled result holds
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // one transaction at a time: busy right after acceptance
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !in_ready_o)

  // the table never runs empty nor overflows
  `ASSERT_PROP(a_count_range, clk_i, rst_ni, out_valid_o |-> (out_data_o.entry_count != 7'd0) && ((POINTS >= 127) || (32'(out_data_o.entry_count) <= POINTS)))

  // full and bad index return no entry data
  `ASSERT_PROP(a_no_data, clk_i, rst_ni, out_valid_o && no_data |-> (out_data_o.read_x == 32'sd0) && (out_data_o.read_y == 32'sd0))

  // a full result always reports position zero
  `ASSERT_NEVER(a_full_pos, clk_i, rst_ni, out_valid_o && (out_data_o.status == skt_pkg::ST_FULL) && (out_data_o.position != 6'd0))

endmodule

bind sorted_keyframe_table skt_checker #(.POINTS(POINTS)) u_skt_checker (.*);
